[sv/masld_pkg.sv]
package masld_pkg;

   // field widths
   localparam int SAMPLE_W = 16;
   localparam int MAG_W    = 15;
   localparam int THR_W    = 8;

   // largest magnitude, also the saturated magnitude of the most negative sample
   localparam int MAG_MAX = 32767;

   // most negative sample code
   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;

   // threshold register value after reset
   localparam logic [THR_W-1:0] THR_RESET = 8'h80;

   // default averaging window length
   localparam int WINDOW_DEFAULT = 100;

   // magnitude of a signed sample, saturating the most negative code
   function automatic logic [MAG_W-1:0] magnitude(input logic signed [SAMPLE_W-1:0] s);
      logic signed [SAMPLE_W-1:0] neg;
      neg = -s;
      if (s == SAMPLE_MIN) begin
         return MAG_W'(MAG_MAX);
      end else if (s[SAMPLE_W-1]) begin
         return neg[MAG_W-1:0];
      end else begin
         return s[MAG_W-1:0];
      end
   endfunction

endpackage

[sv/moving_average_sound_level_detector.sv]
// channel   dir   handshake                 payload
// req_      in    req_valid / req_stall     req_sample (16b signed)
// rsp_      out   rsp_valid / rsp_stall     rsp_mean_level (15b), rsp_above_threshold
// csr_      in    csr_valid / csr_ready     csr_level_threshold (8b)
//
// one sample per cycle unless rsp_stall holds the pipe; a result passes stages a, b, c and d
// the running-sum register loop closes in one add/subtract per cycle
// ring storage is one memory with a registered read port, one write and one read a cycle
// synchronous reset clears the sum, the ring fill flag and all valids; threshold returns to 0x80
// rsp_stall backs up the four stages; req_stall rises only when every stage holds a beat
module moving_average_sound_level_detector
   import masld_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [MAG_W-1:0]           rsp_mean_level,
   output logic                       rsp_above_threshold,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [THR_W-1:0]           csr_level_threshold
);

   // sizes derived from the window length
   localparam int     POS_W   = $clog2(WINDOW);
   localparam int     SUM_MAX = WINDOW * MAG_MAX;
   localparam int     SUM_W   = $clog2(SUM_MAX + 1);
   localparam int     DIV_SH  = SUM_W + $clog2(WINDOW);
   localparam int     RECIP_W = SUM_W + 1;
   localparam int     PROD_W  = SUM_W + RECIP_W;
   localparam longint RECIP_L = ((longint'(1) << DIV_SH) + longint'(WINDOW) - 1)
                                / longint'(WINDOW);
   localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'(RECIP_L);
   localparam logic [POS_W-1:0]   POS_TOP = POS_W'(WINDOW - 1);

   // control
   logic              en_a, en_b, en_c, en_d, accept;
   logic              a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              full_ff, full_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [THR_W-1:0]  thr_ff;

   // payload
   logic [MAG_W-1:0]  a_mag_ff;
   logic [POS_W-1:0]  a_pos_ff;
   logic              a_old_valid_ff;
   logic [MAG_W-1:0]  a_rd_ff;
   logic [MAG_W-1:0]  old_mag;
   logic [PROD_W-1:0] c_prod_ff;
   logic [MAG_W-1:0]  mean;
   logic [MAG_W-1:0]  mean_ff;
   logic              above_ff;

   logic [MAG_W-1:0]  ring_mem [WINDOW];

   // stage enables, backpressure from the output register
   assign en_d      = !d_valid_ff || !rsp_stall;
   assign en_c      = !c_valid_ff || en_d;
   assign en_b      = !b_valid_ff || en_c;
   assign en_a      = !a_valid_ff || en_b;
   assign req_stall = !en_a;
   assign accept    = req_valid && en_a;
   assign csr_ready = 1'b1;

   // write pointer wrap and ring fill tracking
   assign pos_in  = (pos_ff == POS_TOP) ? '0 : pos_ff + POS_W'(1);
   assign full_in = full_ff || (pos_ff == POS_TOP);

   // running sum: drop the oldest magnitude, add the newest
   assign old_mag = a_old_valid_ff ? a_rd_ff : '0;
   assign sum_in  = sum_ff - SUM_W'(old_mag) + SUM_W'(a_mag_ff);

   // quotient by reciprocal multiply, exact over the sum range
   assign mean = c_prod_ff[DIV_SH +: MAG_W];

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         pos_ff     <= '0;
         full_ff    <= 1'b0;
         sum_ff     <= '0;
         thr_ff     <= THR_RESET;
      end else begin
         if (en_a) begin
            a_valid_ff <= req_valid;
         end
         if (en_b) begin
            b_valid_ff <= a_valid_ff;
         end
         if (en_c) begin
            c_valid_ff <= b_valid_ff;
         end
         if (en_d) begin
            d_valid_ff <= c_valid_ff;
         end
         if (accept) begin
            pos_ff  <= pos_in;
            full_ff <= full_in;
         end
         if (a_valid_ff && en_b) begin
            sum_ff <= sum_in;
         end
         if (csr_valid && csr_ready) begin
            thr_ff <= csr_level_threshold;
         end
      end
   end

   // input stage with registered ring read of the oldest entry
   always_ff @(posedge clock) begin
      if (accept) begin
         a_mag_ff       <= magnitude(req_sample);
         a_pos_ff       <= pos_ff;
         a_old_valid_ff <= full_ff;
         a_rd_ff        <= ring_mem[pos_ff];
      end
   end

   // ring write as the beat leaves the input stage
   always_ff @(posedge clock) begin
      if (a_valid_ff && en_b) begin
         ring_mem[a_pos_ff] <= a_mag_ff;
      end
   end

   // multiply stage and result register
   always_ff @(posedge clock) begin
      if (en_c) begin
         c_prod_ff <= PROD_W'(sum_ff) * PROD_W'(RECIP);
      end
      if (en_d) begin
         mean_ff  <= mean;
         above_ff <= (mean > MAG_W'(thr_ff));
      end
   end

   assign rsp_valid           = d_valid_ff;
   assign rsp_mean_level      = mean_ff;
   assign rsp_above_threshold = above_ff;

   // sum stays within the window bound
   a_sum_range: assert property (@(posedge clock) disable iff (reset)
      sum_ff <= SUM_W'(SUM_MAX))
      else $error("window sum out of range");

   // write pointer stays inside the ring
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_TOP)
      else $error("write pointer beyond ring");

   // once the ring has filled it stays filled
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      full_ff |=> full_ff)
      else $error("ring fill flag dropped");

   // a beat in the multiply stage is held while the output is stalled
   a_mul_hold: assert property (@(posedge clock) disable iff (reset)
      (c_valid_ff && d_valid_ff && rsp_stall) |=> (c_valid_ff && $stable(c_prod_ff)))
      else $error("multiply stage lost a beat under stall");

   // the sum only moves when a beat leaves the input stage
   a_sum_move: assert property (@(posedge clock) disable iff (reset)
      !(a_valid_ff && en_b) |=> $stable(sum_ff))
      else $error("window sum changed without a beat");

endmodule
